// File: rtl/core/rnf_pkg.sv
// rnf_pkg: shared constants, state encoding and symbol lookup for the
// radix number formatter. No dependencies.

package rnf_pkg;

    // field and register widths
    localparam int VALUE_W      = 32;
    localparam int SYMBOL_W     = 8;
    localparam int BASE_LEN_W   = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int SYM_IDX_W    = 4;
    localparam int SYM_TAB_W    = 128;

    // alphabet size limit and digit buffer depth
    localparam int MAX_SYMBOLS  = 16;
    localparam int MAX_DIGITS   = 32;
    localparam int DIG_IDX_W    = $clog2(MAX_DIGITS);
    localparam int DIG_CNT_W    = $clog2(MAX_DIGITS + 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LEN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LO = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HI = 2'd2;

    // characters
    localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DUP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SIGN,
        ST_EMIT
    } rnf_state_t;

    // byte idx of the packed alphabet, symbol 0 lowest
    function automatic logic [SYMBOL_W-1:0] symbol_at(
        input logic [SYM_TAB_W-1:0] tab,
        input logic [SYM_IDX_W-1:0] idx
    );
        return tab[{idx, 3'b000} +: SYMBOL_W];
    endfunction

endpackage

// File: rtl/core/rnf_divider.sv
// rnf_divider: restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.

module rnf_divider #(
    parameter int DividendW = 32,
    parameter int DivisorW  = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DividendW-1:0] dividend,
    input  logic [DivisorW-1:0]  divisor,
    output logic                 done,
    output logic [DividendW-1:0] quotient,
    output logic [DivisorW-1:0]  remainder
);

    localparam int CntW = $clog2(DividendW);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CntW-1:0]      cnt_reg;
    logic [DivisorW-1:0]  rem_reg;
    logic [DividendW-1:0] quo_reg;

    logic [DivisorW:0]    trial;
    logic [DivisorW:0]    diff;
    logic                 fits;

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_reg, quo_reg[DividendW-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DividendW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DividendW-2:0], fits};
            rem_reg <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/radix_number_formatter_unit.sv
// radix_number_formatter_unit: signed 32-bit value to text in a configurable radix.
// Uses rnf_pkg and rnf_divider.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_ready    value
//   out      out        out_valid / out_ready  symbol, last
//
// one request at a time: the alphabet check runs first
// (one symbol compare per cycle), then each digit takes a full run of the
// shared bit-serial divider
// output symbols leave one per cycle through the output register while out_ready is high
// a finished symbol may wait in the output register while the next request is taken
// reset clears the state machine, the output valid and the config registers to zero
// config is taken only while idle; an invalid alphabet gives no output at all

module radix_number_formatter_unit #(
    parameter int MaxSymbols = rnf_pkg::MAX_SYMBOLS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rnf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rnf_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input requests
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rnf_pkg::VALUE_W-1:0]   value,
    // output symbols
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rnf_pkg::SYMBOL_W-1:0]         symbol,
    output logic                                 last
);

    // radix counter width holds 0..MaxSymbols, digit width holds 0..MaxSymbols-1
    localparam int RadW = $clog2(MaxSymbols + 1);
    localparam int DigW = (MaxSymbols > 2) ? $clog2(MaxSymbols) : 1;
    localparam int IdxW = rnf_pkg::SYM_IDX_W;
    localparam int ValW = rnf_pkg::VALUE_W;
    localparam int SymW = rnf_pkg::SYMBOL_W;
    localparam int CntW = rnf_pkg::DIG_CNT_W;
    localparam int DixW = rnf_pkg::DIG_IDX_W;
    localparam int BlW  = rnf_pkg::BASE_LEN_W;

    // config registers
    logic [BlW-1:0]                    base_len_reg;
    logic [rnf_pkg::CFG_DATA_W-1:0]    symbols_lo_reg;
    logic [rnf_pkg::CFG_DATA_W-1:0]    symbols_hi_reg;

    // sequencer state
    rnf_pkg::rnf_state_t state_reg, state_next;
    logic [RadW-1:0]   i_reg, i_next;
    logic [RadW-1:0]   j_reg, j_next;
    logic [RadW-1:0]   radix_reg, radix_next;
    logic [SymW-1:0]   sym_i_reg, sym_i_next;
    logic [ValW-1:0]   mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [CntW-1:0]   nd_reg, nd_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [SymW-1:0]   symbol_reg, symbol_next;
    logic              last_reg, last_next;

    // digit buffer, least significant digit first
    logic [DigW-1:0]   digit_mem [rnf_pkg::MAX_DIGITS];
    logic              dig_we;

    // divider hookup
    logic              div_start;
    logic              div_done;
    logic [ValW-1:0]   div_quo;
    logic [RadW-1:0]   div_rem;

    logic [rnf_pkg::SYM_TAB_W-1:0] sym_tab;
    logic [RadW-1:0]   lim;
    logic [SymW-1:0]   sym_at_i;
    logic [SymW-1:0]   sym_at_j;
    logic [DixW-1:0]   rd_idx;
    logic [SymW-1:0]   sym_out;
    logic              can_load;

    assign sym_tab  = {symbols_hi_reg, symbols_lo_reg};

    // alphabet length limited to the supported size
    assign lim = (base_len_reg > BlW'(MaxSymbols)) ? RadW'(MaxSymbols)
                                                   : RadW'(base_len_reg);

    assign sym_at_i = rnf_pkg::symbol_at(sym_tab, IdxW'(i_reg));
    assign sym_at_j = rnf_pkg::symbol_at(sym_tab, IdxW'(j_reg));

    // most significant stored digit is the next one out
    assign rd_idx   = DixW'(nd_reg - 1'b1);
    assign sym_out  = rnf_pkg::symbol_at(sym_tab, IdxW'(digit_mem[rd_idx]));

    // output register free or being drained this cycle
    assign can_load = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == rnf_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == rnf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg   <= '0;
            symbols_lo_reg <= '0;
            symbols_hi_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rnf_pkg::CFG_BASE_LEN:   base_len_reg   <= cfg_data[BlW-1:0];
                rnf_pkg::CFG_SYMBOLS_LO: symbols_lo_reg <= cfg_data;
                rnf_pkg::CFG_SYMBOLS_HI: symbols_hi_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // shared bit-serial divider, one digit per run
    rnf_divider #(
        .DividendW (ValW),
        .DivisorW  (RadW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            digit_mem[nd_reg[DixW-1:0]] <= DigW'(div_rem);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rnf_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            radix_reg     <= '0;
            sym_i_reg     <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
            symbol_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            radix_reg     <= radix_next;
            sym_i_reg     <= sym_i_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
            symbol_reg    <= symbol_next;
            last_reg      <= last_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        radix_next     = radix_reg;
        sym_i_next     = sym_i_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        nd_next        = nd_reg;
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        div_start      = 1'b0;
        dig_we         = 1'b0;

        // downstream took the pending symbol
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rnf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // magnitude at 32 bits unsigned covers the most negative value
                    neg_next   = value[ValW-1];
                    mag_next   = value[ValW-1] ? (ValW'(0) - ValW'(value)) : ValW'(value);
                    i_next     = '0;
                    state_next = rnf_pkg::ST_SCAN;
                end
            end

            rnf_pkg::ST_SCAN:
            begin
                if ((i_reg == lim) || (sym_at_i == rnf_pkg::CHAR_NUL))
                begin
                    // end of alphabet: length is the radix
                    radix_next = i_reg;
                    nd_next    = '0;
                    if (i_reg < RadW'(2))
                    begin
                        state_next = rnf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = rnf_pkg::ST_DIV_START;
                    end
                end
                else if ((sym_at_i == rnf_pkg::CHAR_PLUS) || (sym_at_i == rnf_pkg::CHAR_MINUS))
                begin
                    state_next = rnf_pkg::ST_IDLE;
                end
                else
                begin
                    sym_i_next = sym_at_i;
                    j_next     = '0;
                    state_next = rnf_pkg::ST_DUP;
                end
            end

            rnf_pkg::ST_DUP:
            begin
                // compare symbol i against each earlier symbol, one per cycle
                if (j_reg == i_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = rnf_pkg::ST_SCAN;
                end
                else if (sym_at_j == sym_i_reg)
                begin
                    state_next = rnf_pkg::ST_IDLE;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            rnf_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = rnf_pkg::ST_DIV_WAIT;
            end

            rnf_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    dig_we   = 1'b1;
                    nd_next  = nd_reg + 1'b1;
                    mag_next = div_quo;
                    if ((div_quo == '0) || (nd_reg == CntW'(rnf_pkg::MAX_DIGITS - 1)))
                    begin
                        state_next = rnf_pkg::ST_SIGN;
                    end
                    else
                    begin
                        state_next = rnf_pkg::ST_DIV_START;
                    end
                end
            end

            rnf_pkg::ST_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = rnf_pkg::ST_EMIT;
                end
                else if (can_load)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = rnf_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = rnf_pkg::ST_EMIT;
                end
            end

            rnf_pkg::ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = sym_out;
                    last_next      = (nd_reg == CntW'(1));
                    nd_next        = nd_reg - 1'b1;
                    if (nd_reg == CntW'(1))
                    begin
                        state_next = rnf_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = rnf_pkg::ST_IDLE;
            end
        endcase
    end

    // digit count stays within the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= CntW'(rnf_pkg::MAX_DIGITS))
    else $error("digit count beyond buffer depth");

    // emitting with an empty buffer would read a stale digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rnf_pkg::ST_EMIT) |-> (nd_reg != '0))
    else $error("emit with no digits stored");

    // divider remainder must be a valid digit of the radix
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rnf_pkg::ST_DIV_WAIT && div_done) |-> (div_rem < radix_reg))
    else $error("remainder not below radix");

    // digits are only produced for an accepted alphabet
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rnf_pkg::ST_DIV_START) |-> (radix_reg >= RadW'(2)))
    else $error("division started with a radix below two");

endmodule
